/* hdl/sbbh_pkg.sv */
// shared constants and codes for the swept box against box hit test
package sbbh_pkg;

    // internal time word, signed, saturated to plus or minus time_cap
    localparam int TIME_WIDTH = 48;
    localparam logic [TIME_WIDTH-1:0] TIME_CAP = {1'b0, {(TIME_WIDTH-1){1'b1}}};
    localparam logic [TIME_WIDTH-1:0] TIME_MOST_NEG = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    // still threshold register
    localparam int THRESH_WIDTH = 16;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd1;

    // axis codes
    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    // face codes
    localparam logic [2:0] FACE_NEG_X = 3'd0;
    localparam logic [2:0] FACE_POS_Y = 3'd3;

endpackage

/* hdl/sbbh_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module sbbh_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW_CNT = $clog2(NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW_CNT-1:0] cnt_reg;
    logic [NW-1:0]     quo_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     div_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // trial subtract of the next dividend bit
    always_comb begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW_CNT'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW_CNT'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/swept_box_box_hit.sv */
// swept box against static box slab test, top level
//
// channel   | dir | fields
// s_axis_*  | in  | axis, moving_min, moving_max, target_min, target_max, displacement
// m_axis_*  | out | hit, hit_time, hit_x, hit_y, hit_z, hit_face
// cfg_wr_*  | in  | still_threshold
//
// an axis item with movement makes two passes through the shared radix-2 divider;
// a still item skips the divider. the z item adds an emit step, and when the boxes
// start apart and hit, high, low and sum steps per axis on the shared multiplier
// for the hit point; the emit waits while the output register is still full
// s_axis_tready is high only when the sequencer is idle, so a stalled emit holds it low
// a result waits in the output register until taken; reset clears control and query state
module swept_box_box_hit #(
    parameter int COORD_WIDTH        = 32,
    parameter int TIME_FRACTION_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sbbh_pkg::THRESH_WIDTH-1:0]  cfg_wr_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // axis, moving_min, moving_max, target_min, target_max, displacement
    input  logic [((2+5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // hit, hit_time, hit_x, hit_y, hit_z, hit_face
    output logic [((TIME_FRACTION_BITS+5+3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    import sbbh_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int F   = TIME_FRACTION_BITS;
    localparam int NW  = CW + 1 + F;
    localparam int QW  = (NW > TIME_WIDTH) ? NW : TIME_WIDTH;
    localparam int MW  = CW + F + 1;
    localparam int PW  = CW + F + 2;
    localparam int OW  = ((F + 5 + 3*CW + 7) / 8) * 8;
    localparam logic signed [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1) << F;
    localparam logic [CW-1:0] LO_MASK = CW'((64'd1 << F) - 64'd1);
    localparam logic signed [PW:0] COORD_HI = (PW+1)'((65'sd1 <<< (CW-1)) - 65'sd1);
    localparam logic signed [PW:0] COORD_LO = -COORD_HI - (PW+1)'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIV_LO, S_DIV_HI, S_CLIP, S_FINISH,
        S_PT_HI, S_PT_LO, S_PT_SUM, S_EMIT
    } state_t;

    state_t state_reg;

    logic [THRESH_WIDTH-1:0] thresh_reg;

    // latched item
    logic [1:0]           axis_reg;
    logic signed [CW-1:0] mmin_reg, mmax_reg, tmin_reg, tmax_reg, disp_reg;

    // query state
    logic signed [TIME_WIDTH-1:0] near_reg, far_reg;
    logic [2:0]                   face_reg;
    logic                         missed_reg, outside_reg;
    logic signed [CW:0]           center_store [3];
    logic signed [CW-1:0]         motion_store [3];

    // divider interface
    logic                         div_start_reg;
    logic [NW-1:0]                dividend_reg;
    logic [CW-1:0]                dmag_reg;
    logic                         div_done, div_busy;
    logic [NW-1:0]                div_q;
    logic signed [TIME_WIDTH-1:0] te_reg, tx_reg;

    // hit point loop
    logic [1:0]           k_reg;
    logic [MW-1:0]        prod_hi_reg, prod_lo_reg;

    // working result and output register
    logic                 res_hit_reg;
    logic [F:0]           res_time_reg;
    logic [CW-1:0]        res_pt_reg [3];
    logic [2:0]           res_face_reg;
    logic                 m_valid_reg;
    logic [OW-1:0]        m_data_reg;

    // combinational helpers
    logic signed [CW:0]   num_lo, num_hi;
    logic [CW:0]          num_lo_mag, num_hi_mag;
    logic [CW-1:0]        d_mag;
    logic                 still, outside;
    logic                 neg_lo, neg_hi;
    logic [QW-1:0]        q_ext;
    logic [TIME_WIDTH-1:0] t_mag;
    logic signed [TIME_WIDTH-1:0] t_signed;
    logic                 rev;
    logic signed [TIME_WIDTH-1:0] t_enter, t_exit, near_new, far_new;
    logic [CW-1:0]        pm_mag, mul_a;
    logic [F:0]           mul_b;
    logic [MW-1:0]        prod;
    logic [PW-1:0]        pt_p;
    logic signed [PW:0]   pt_off, pt_v;
    logic [CW-1:0]        pt_sat;
    logic                 s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // slab numerators, exact in doubled units after cancelling the factor of two
    always_comb begin
        num_lo     = (CW+1)'(tmin_reg) - (CW+1)'(mmax_reg);
        num_hi     = (CW+1)'(tmax_reg) - (CW+1)'(mmin_reg);
        num_lo_mag = num_lo[CW] ? -num_lo : num_lo;
        num_hi_mag = num_hi[CW] ? -num_hi : num_hi;
        d_mag      = disp_reg[CW-1] ? -disp_reg : disp_reg;
        still      = (disp_reg == '0) || (d_mag < CW'(thresh_reg));
        outside    = !((tmin_reg <= mmax_reg) && (mmin_reg <= tmax_reg));
        neg_lo     = num_lo[CW] ^ disp_reg[CW-1];
        neg_hi     = num_hi[CW] ^ disp_reg[CW-1];
    end

    // saturate and sign the quotient
    always_comb begin
        q_ext = QW'(div_q);
        if (q_ext > QW'(TIME_CAP)) begin
            t_mag = TIME_CAP;
        end else begin
            t_mag = q_ext[TIME_WIDTH-1:0];
        end
        t_signed = (state_reg == S_DIV_LO ? neg_lo : neg_hi) ? -t_mag : t_mag;
    end

    // interval clip
    always_comb begin
        rev      = te_reg > tx_reg;
        t_enter  = rev ? tx_reg : te_reg;
        t_exit   = rev ? te_reg : tx_reg;
        near_new = (t_enter > near_reg) ? t_enter : near_reg;
        far_new  = (t_exit < far_reg) ? t_exit : far_reg;
    end

    // shared multiplier and hit point sum
    always_comb begin
        pm_mag = motion_store[k_reg][CW-1] ? -motion_store[k_reg] : motion_store[k_reg];
        mul_a  = (state_reg == S_PT_LO) ? (pm_mag & LO_MASK) : (pm_mag >> F);
        mul_b  = near_reg[F:0];
        prod   = MW'(mul_a) * MW'(mul_b);
        pt_p   = PW'(prod_hi_reg) + PW'(prod_lo_reg >> F);
        pt_off = motion_store[k_reg][CW-1] ? -$signed({1'b0, pt_p}) : $signed({1'b0, pt_p});
        pt_v   = (PW+1)'($signed(center_store[k_reg][CW:1])) + pt_off;
        if (pt_v > COORD_HI) begin
            pt_sat = COORD_HI[CW-1:0];
        end else if (pt_v < COORD_LO) begin
            pt_sat = COORD_LO[CW-1:0];
        end else begin
            pt_sat = pt_v[CW-1:0];
        end
    end

    sbbh_div #(
        .NW (NW),
        .DW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (dividend_reg),
        .divisor  (dmag_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // per-axis stores, undefined until written
    always_ff @(posedge aclk) begin
        if (state_reg == S_PREP) begin
            center_store[axis_reg] <= (CW+1)'(mmin_reg) + (CW+1)'(mmax_reg);
            motion_store[axis_reg] <= disp_reg;
        end
    end

    // divider start pulse for each of the two passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == S_PREP && !still)
                          || (state_reg == S_DIV_LO && div_done);
        end
    end

    // output valid, set on emit and cleared once the transfer is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && (!m_valid_reg || m_axis_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // sequencer, query state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            near_reg      <= TIME_MOST_NEG;
            far_reg       <= TIME_CAP;
            face_reg      <= FACE_NEG_X;
            missed_reg    <= 1'b0;
            outside_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept && s_axis_tdata[1:0] != AXIS_BAD) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (outside) begin
                        outside_reg <= 1'b1;
                    end
                    if (still) begin
                        if (outside) begin
                            missed_reg <= 1'b1;
                        end
                        state_reg <= S_FINISH;
                    end else begin
                        dividend_reg  <= {num_lo_mag, {F{1'b0}}};
                        dmag_reg      <= d_mag;
                        state_reg     <= S_DIV_LO;
                    end
                end
                S_DIV_LO: begin
                    if (div_done) begin
                        te_reg        <= t_signed;
                        dividend_reg  <= {num_hi_mag, {F{1'b0}}};
                        state_reg     <= S_DIV_HI;
                    end
                end
                S_DIV_HI: begin
                    if (div_done) begin
                        tx_reg    <= t_signed;
                        state_reg <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    near_reg <= near_new;
                    far_reg  <= far_new;
                    if (t_enter > near_reg) begin
                        face_reg <= {axis_reg, rev};
                    end
                    if (!(near_new <= far_new && far_new >= 0)) begin
                        missed_reg <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (axis_reg != AXIS_Z) begin
                        state_reg <= S_IDLE;
                    end else if (!outside_reg) begin
                        res_hit_reg   <= 1'b1;
                        res_time_reg  <= '0;
                        res_pt_reg[0] <= center_store[0][CW:1];
                        res_pt_reg[1] <= center_store[1][CW:1];
                        res_pt_reg[2] <= center_store[2][CW:1];
                        res_face_reg  <= FACE_POS_Y;
                        state_reg     <= S_EMIT;
                    end else if (!missed_reg && near_reg >= 0 && near_reg <= TIME_ONE) begin
                        res_hit_reg  <= 1'b1;
                        res_time_reg <= near_reg[F:0];
                        res_face_reg <= face_reg;
                        k_reg        <= AXIS_X;
                        state_reg    <= S_PT_HI;
                    end else begin
                        res_hit_reg   <= 1'b0;
                        res_time_reg  <= '0;
                        res_pt_reg[0] <= '0;
                        res_pt_reg[1] <= '0;
                        res_pt_reg[2] <= '0;
                        res_face_reg  <= FACE_NEG_X;
                        state_reg     <= S_EMIT;
                    end
                end
                S_PT_HI: begin
                    prod_hi_reg <= prod;
                    state_reg   <= S_PT_LO;
                end
                S_PT_LO: begin
                    prod_lo_reg <= prod;
                    state_reg   <= S_PT_SUM;
                end
                S_PT_SUM: begin
                    res_pt_reg[k_reg] <= pt_sat;
                    if (k_reg == AXIS_Z) begin
                        state_reg <= S_EMIT;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_PT_HI;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg  <= OW'({res_face_reg, res_pt_reg[2], res_pt_reg[1],
                                            res_pt_reg[0], res_time_reg, res_hit_reg});
                        near_reg    <= TIME_MOST_NEG;
                        far_reg     <= TIME_CAP;
                        face_reg    <= FACE_NEG_X;
                        missed_reg  <= 1'b0;
                        outside_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            axis_reg <= s_axis_tdata[1:0];
            mmin_reg <= s_axis_tdata[2 +: CW];
            mmax_reg <= s_axis_tdata[2+CW +: CW];
            tmin_reg <= s_axis_tdata[2+2*CW +: CW];
            tmax_reg <= s_axis_tdata[2+3*CW +: CW];
            disp_reg <= s_axis_tdata[2+4*CW +: CW];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // a miss carries zero time and face
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg[0] |-> m_data_reg[F+1:1] == '0
            && m_data_reg[F+2+3*CW +: 3] == FACE_NEG_X)
        else $error("miss result with nonzero fields");

    // the divider is never running while a new item can be taken
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !div_busy)
        else $error("divider busy while idle");

    // a reported hit time never exceeds one step
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[0] |-> m_data_reg[F+1:1] <= (F+1)'(1) << F)
        else $error("hit time beyond one step");

endmodule
